// ===== hw/rtl/sxc_pkg.sv =====
package sxc_pkg;

	localparam int BYTE_W          = 8;
	localparam int REG_W           = 8;
	localparam int CFG_IDX_W       = 2;
	localparam int OFF_W           = 15;
	localparam int MASK_W          = 6;
	localparam int CNT_W           = 14;
	localparam int COL_W           = 5;
	localparam int RIB_W           = 2;
	localparam int BAND_W          = 7;
	localparam int CELLS_PER_BYTE  = 4;
	localparam int TDATA_W         = 40;
	localparam int MAX_ROW_BYTES_DEF = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE    = 2'd2;

	localparam logic [REG_W-1:0] RST_SPRITE_WIDTH  = 8'd16;
	localparam logic [REG_W-1:0] RST_SPRITE_HEIGHT = 8'd24;
	localparam logic [REG_W-1:0] RST_ROW_STRIDE    = 8'd80;

	// mask bit positions
	localparam int MB_R0_L = 0;
	localparam int MB_R0_R = 1;
	localparam int MB_R1_L = 2;
	localparam int MB_R1_R = 3;
	localparam int MB_R2_L = 4;
	localparam int MB_R2_R = 5;

	// four candidate cells of one final-row byte, plus their base offset and the summary flag
	typedef struct packed {
		logic [CELLS_PER_BYTE-1:0]             pend;
		logic [CELLS_PER_BYTE-1:0][MASK_W-1:0] mask;
		logic [OFF_W-1:0]                      base;
		logic                                  summary;
	} grp_t;

endpackage

// ===== hw/rtl/bitmap_to_sextant_cell_list_core.sv =====
// Turns a 1-bit-per-pixel sprite, fed one byte per item row after row (leftmost
// pixel in bit 7, rows padded to whole bytes), into a list of non-empty 2x3 cells:
// offset = band * row_stride + cell column, a 6-bit mask and a running count,
// then one summary item (tuser = 0) with the total. Bytes of rows 0 and 1 of a
// band sit in two row memories of MAX_ROW_BYTES bytes each until the band's last
// row arrives. A final-row byte yields one item per non-empty cell, plus the
// summary item when it ends the sprite; the output register delivers one item per
// cycle while m_axis_tready is high, and bytes wait while items are still pending.
// Results pass the input stage, emit stage and output registers. A configuration
// write restarts the sprite and must be made while the block is idle.
module bitmap_to_sextant_cell_list_core #(
	parameter int MAX_ROW_BYTES = sxc_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sxc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sxc_pkg::REG_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [sxc_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] pixel_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [14:0] cell_offset, [20:15] cell_mask, [34:21] cells_so_far, [39:35] zero
	output logic [sxc_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic                               m_axis_tuser,   // [0] is_cell
	output logic                               m_axis_tlast
);

	sxc_pkg::grp_t grp;
	logic grp_valid, grp_ready, restart;
	logic [sxc_pkg::OFF_W-1:0]  offset;
	logic [sxc_pkg::MASK_W-1:0] mask;
	logic [sxc_pkg::CNT_W-1:0]  count;

	assign restart = cfg_we && (cfg_index == sxc_pkg::REG_SPRITE_WIDTH ||
		cfg_index == sxc_pkg::REG_SPRITE_HEIGHT || cfg_index == sxc_pkg::REG_ROW_STRIDE);

	sxc_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp)
	);

	sxc_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.grp_valid   (grp_valid),
		.grp_ready   (grp_ready),
		.grp         (grp),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_is_cell (m_axis_tuser),
		.out_offset  (offset),
		.out_mask    (mask),
		.out_count   (count),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, count, mask, offset};

endmodule

// ===== hw/rtl/sxc_front.sv =====
module sxc_front #(
	parameter int MAX_ROW_BYTES = sxc_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sxc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sxc_pkg::REG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sxc_pkg::BYTE_W-1:0]        in_byte,
	output logic                              grp_valid,
	input  logic                              grp_ready,
	output sxc_pkg::grp_t                     grp
);

	localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

	logic [sxc_pkg::REG_W-1:0] width_q, height_q, stride_q;
	logic [sxc_pkg::COL_W-1:0] col_q;
	logic [sxc_pkg::RIB_W-1:0] rib_q;
	logic [7:0]                rows_q;
	logic [sxc_pkg::BAND_W-1:0] band_q;

	logic [sxc_pkg::BYTE_W-1:0] row0_mem [MAX_ROW_BYTES];
	logic [sxc_pkg::BYTE_W-1:0] row1_mem [MAX_ROW_BYTES];
	logic [sxc_pkg::BYTE_W-1:0] rd0_q, rd1_q;

	logic                        v_s1;
	logic [sxc_pkg::BYTE_W-1:0]  pix_s1;
	logic [sxc_pkg::COL_W-1:0]   col_s1;
	logic [sxc_pkg::RIB_W-1:0]   rib_s1;
	logic                        fin_s1;
	logic                        inr_s1;
	logic                        sum_s1;
	logic [sxc_pkg::OFF_W-1:0]   boff_s1;

	logic [7:0] w_eff, h_eff;
	logic [5:0] row_bytes;
	logic [7:0] w_cells;
	logic       accept, final_row, row_end, summary, in_range, cfg_hit;
	logic [7:0] rows_next;
	logic [AW-1:0] addr;

	assign w_eff     = (width_q == '0) ? 8'd1 : width_q;
	assign h_eff     = (height_q == '0) ? 8'd1 : height_q;
	assign row_bytes = 6'(({1'b0, w_eff} + 9'd7) >> 3);
	assign w_cells   = 8'(({1'b0, w_eff} + 9'd1) >> 1);

	assign in_ready  = !v_s1 || grp_ready;
	assign accept    = in_valid && in_ready;
	assign rows_next = rows_q + 8'd1;
	assign final_row = (rib_q >= 2'd2) || ({1'b0, rows_q} + 9'd1 >= {1'b0, h_eff});
	assign row_end   = ({1'b0, col_q} + 6'd1) >= row_bytes;
	assign summary   = row_end && (rows_next >= h_eff);
	assign in_range  = {1'b0, col_q} < 6'(MAX_ROW_BYTES);
	assign addr      = col_q[AW-1:0];
	assign cfg_hit   = cfg_we && (cfg_index == sxc_pkg::REG_SPRITE_WIDTH ||
		cfg_index == sxc_pkg::REG_SPRITE_HEIGHT || cfg_index == sxc_pkg::REG_ROW_STRIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sxc_pkg::RST_SPRITE_WIDTH;
			height_q <= sxc_pkg::RST_SPRITE_HEIGHT;
			stride_q <= sxc_pkg::RST_ROW_STRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sxc_pkg::REG_SPRITE_WIDTH:  width_q  <= cfg_data;
				sxc_pkg::REG_SPRITE_HEIGHT: height_q <= cfg_data;
				sxc_pkg::REG_ROW_STRIDE:    stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position counters advance on each accepted item and clear on a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rib_q  <= '0;
			rows_q <= '0;
			band_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			rib_q  <= '0;
			rows_q <= '0;
			band_q <= '0;
		end else if (accept) begin
			if (!row_end) begin
				col_q <= col_q + 5'd1;
			end else if (summary) begin
				col_q  <= '0;
				rib_q  <= '0;
				rows_q <= '0;
				band_q <= '0;
			end else begin
				col_q  <= '0;
				rows_q <= rows_next;
				if (final_row) begin
					rib_q  <= '0;
					band_q <= band_q + 7'd1;
				end else begin
					rib_q <= rib_q + 2'd1;
				end
			end
		end
	end

	// row store: rows 0 and 1 of the band, read as the item enters
	always_ff @(posedge clk) begin
		if (accept && !final_row && in_range) begin
			if (rib_q == 2'd0) begin
				row0_mem[addr] <= in_byte;
			end else begin
				row1_mem[addr] <= in_byte;
			end
		end
		if (accept) begin
			rd0_q <= row0_mem[addr];
			rd1_q <= row1_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= in_byte;
			col_s1  <= col_q;
			rib_s1  <= rib_q;
			fin_s1  <= final_row;
			inr_s1  <= in_range;
			sum_s1  <= summary;
			boff_s1 <= sxc_pkg::OFF_W'(band_q) * sxc_pkg::OFF_W'(stride_q);
		end
	end

	logic [sxc_pkg::BYTE_W-1:0] r0, r1, r2;
	logic [6:0] cc;
	logic [7:0] p0;
	logic       cv, rc;
	logic [sxc_pkg::MASK_W-1:0] m;

	always_comb begin
		r0 = (rib_s1 == 2'd0) ? pix_s1 : (inr_s1 ? rd0_q : '0);
		r1 = (rib_s1 == 2'd1) ? pix_s1 : (inr_s1 ? rd1_q : '0);
		r2 = pix_s1;
		cc = '0;
		p0 = '0;
		cv = 1'b0;
		rc = 1'b0;
		m  = '0;
		grp.pend    = '0;
		grp.mask    = '0;
		grp.base    = boff_s1 + sxc_pkg::OFF_W'({col_s1, 2'b00});
		grp.summary = sum_s1;
		for (int k = 0; k < sxc_pkg::CELLS_PER_BYTE; k++) begin
			cc = {col_s1, 2'(k)};
			p0 = {cc, 1'b0};
			cv = {1'b0, cc} < w_cells;
			rc = ({1'b0, p0} + 9'd1) < {1'b0, w_eff};
			m  = '0;
			m[sxc_pkg::MB_R0_L] = r0[7-2*k];
			m[sxc_pkg::MB_R0_R] = rc && r0[6-2*k];
			if (rib_s1 >= 2'd1) begin
				m[sxc_pkg::MB_R1_L] = r1[7-2*k];
				m[sxc_pkg::MB_R1_R] = rc && r1[6-2*k];
			end
			if (rib_s1 >= 2'd2) begin
				m[sxc_pkg::MB_R2_L] = r2[7-2*k];
				m[sxc_pkg::MB_R2_R] = rc && r2[6-2*k];
			end
			grp.mask[k] = m;
			grp.pend[k] = fin_s1 && cv && (m != '0);
		end
	end

	assign grp_valid = v_s1;

endmodule

// ===== hw/rtl/sxc_emit.sv =====
module sxc_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  logic                          grp_valid,
	output logic                          grp_ready,
	input  sxc_pkg::grp_t                 grp,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_is_cell,
	output logic [sxc_pkg::OFF_W-1:0]     out_offset,
	output logic [sxc_pkg::MASK_W-1:0]    out_mask,
	output logic [sxc_pkg::CNT_W-1:0]     out_count,
	output logic                          out_last
);

	logic [sxc_pkg::CELLS_PER_BYTE-1:0]             pend_q;
	logic                                           sum_q;
	logic [sxc_pkg::CELLS_PER_BYTE-1:0][sxc_pkg::MASK_W-1:0] mask_q;
	logic [sxc_pkg::OFF_W-1:0]                      base_q;
	logic [sxc_pkg::CNT_W-1:0]                      count_q;
	logic                                           out_valid_q;

	logic [sxc_pkg::CELLS_PER_BYTE-1:0] pend_nx;
	logic [1:0] k;
	logic busy, has_cell, out_load, emit, last_emit, ex_free;

	always_comb begin
		if (pend_q[0]) begin
			k = 2'd0;
		end else if (pend_q[1]) begin
			k = 2'd1;
		end else if (pend_q[2]) begin
			k = 2'd2;
		end else begin
			k = 2'd3;
		end
	end

	assign has_cell  = pend_q != '0;
	assign busy      = has_cell || sum_q;
	assign pend_nx   = pend_q & (pend_q - 4'd1);
	assign out_load  = !out_valid_q || out_ready;
	assign emit      = busy && out_load;
	assign last_emit = has_cell ? (pend_nx == '0 && !sum_q) : 1'b1;
	assign ex_free   = !busy || (emit && last_emit);
	assign grp_ready = ex_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sum_q  <= 1'b0;
		end else if (grp_valid && ex_free) begin
			pend_q <= grp.pend;
			sum_q  <= grp.summary;
		end else if (emit) begin
			if (has_cell) begin
				pend_q <= pend_nx;
			end else begin
				sum_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && ex_free) begin
			mask_q <= grp.mask;
			base_q <= grp.base;
		end
	end

	// running cell count; the summary hands it out and clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (restart) begin
			count_q <= '0;
		end else if (emit) begin
			count_q <= has_cell ? count_q + 14'd1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_is_cell <= has_cell;
			out_offset  <= has_cell ? base_q + sxc_pkg::OFF_W'(k) : '0;
			out_mask    <= has_cell ? mask_q[k] : '0;
			out_count   <= has_cell ? count_q + 14'd1 : count_q;
			out_last    <= last_emit;
		end
	end

	assign out_valid = out_valid_q;

endmodule
